/* design/erg_pkg.sv */
package erg_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Obstacle classes; the fourth code behaves as a shelf.
  localparam logic [1:0] KIND_SCREEN = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_SCREEN = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;
  localparam logic [1:0] CFG_SHELF  = 2'd3;

  // Width of edge distances: edge positions reach from -32768 to 65534, distances from -98302 to 98302.
  localparam int unsigned D_W = 19;
  // Width of the resistance accumulators: magnitudes stay below 1024.
  localparam int unsigned R_W = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // One stored obstacle rectangle, as held in the table memory.
  typedef struct packed {
    logic [1:0]         kind;
    logic [14:0]        w;
    logic [14:0]        h;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } obst_t;

  // Proposed and previous geometry of the query in progress.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0]        pw;
    logic [14:0]        ph;
  } query_t;

  // Direction of motion on one axis.
  typedef struct packed {
    logic pos_gt;
    logic pos_lt;
    logic size_gt;
    logic size_ne;
  } axis_mot_t;

  typedef struct packed {
    axis_mot_t x;
    axis_mot_t y;
  } motion_t;

  typedef struct packed {
    logic [9:0] screen;
    logic [9:0] window;
    logic [9:0] shelf;
  } resist_t;

  typedef struct packed {
    logic signed [R_W-1:0] r_pos;
    logic signed [R_W-1:0] r_size;
  } axis_acc_t;

  typedef struct packed {
    axis_acc_t x;
    axis_acc_t y;
  } acc_t;

endpackage

/* design/erg_ram.sv */
module erg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/erg_eval.sv */
module erg_eval import erg_pkg::*; (
  input  query_t  query_i,
  input  motion_t mot_i,
  input  obst_t   obst_i,
  input  resist_t resist_i,
  input  acc_t    acc_i,
  output acc_t    acc_o
);

  // Far edges are the right or bottom edge, near edges the left or top edge.
  // Holders and obstacles reduce to the same tests once the obstacle edge
  // that matters has been chosen.
  function automatic axis_acc_t axis_step(
    input logic signed [15:0] pos,
    input logic [14:0]        size,
    input logic signed [15:0] ppos,
    input logic [14:0]        psize,
    input logic signed [15:0] a,
    input logic [14:0]        asize,
    input logic               span_ok,
    input logic               hold,
    input logic [9:0]         v,
    input axis_mot_t          mot,
    input axis_acc_t          acc
  );
    axis_acc_t             res;
    logic signed [D_W-1:0] pos_e, ppos_e, a_e, a_end, far_a, near_a;
    logic signed [D_W-1:0] e, pe, n, pn, v_e, rp_e, rs_e;
    logic                  far_hit, near_hit;
    res    = acc;
    pos_e  = D_W'(pos);
    ppos_e = D_W'(ppos);
    a_e    = D_W'(a);
    a_end  = a_e + D_W'(asize);
    far_a  = hold ? a_end : a_e;
    near_a = hold ? a_e : a_end;
    e      = pos_e + D_W'(size) - far_a;
    pe     = ppos_e + D_W'(psize) - far_a;
    n      = near_a - pos_e;
    pn     = near_a - ppos_e;
    v_e    = D_W'(v);
    rp_e   = D_W'(acc.r_pos);
    rs_e   = D_W'(acc.r_size);
    far_hit  = (e > 0) && (pe <= 0) && (e <= v_e);
    near_hit = (n > 0) && (pn <= 0) && (n <= v_e);
    if (span_ok) begin
      if (mot.pos_gt) begin
        if (far_hit && (rp_e > -e)) begin
          res.r_pos = R_W'(-e);
        end
      end else if (mot.pos_lt) begin
        if (near_hit && (rp_e < n)) begin
          res.r_pos  = R_W'(n);
          res.r_size = R_W'(-n);
        end
      end else if (mot.size_gt) begin
        if (far_hit && (rs_e > -e)) begin
          res.r_size = R_W'(-e);
        end
      end
    end
    return res;
  endfunction

  logic                  hold;
  logic [9:0]            v;
  logic signed [D_W-1:0] qx, qy, ox, oy;
  logic signed [D_W-1:0] qw, qh, obw, obh;
  logic                  span_y, span_x;

  always_comb begin
    hold = (obst_i.kind == KIND_SCREEN);
    unique case (obst_i.kind)
      KIND_SCREEN: v = resist_i.screen;
      KIND_WINDOW: v = resist_i.window;
      default:     v = resist_i.shelf;
    endcase
  end

  // Vertical spans must overlap for horizontal edges to interact, and so on.
  // Sizes are widened into signed values so that the compares stay signed.
  assign qx  = D_W'(query_i.x);
  assign qy  = D_W'(query_i.y);
  assign ox  = D_W'(obst_i.x);
  assign oy  = D_W'(obst_i.y);
  assign qw  = D_W'(query_i.w);
  assign qh  = D_W'(query_i.h);
  assign obw = D_W'(obst_i.w);
  assign obh = D_W'(obst_i.h);
  assign span_y = !((qy + qh <= oy) || (qy >= oy + obh));
  assign span_x = !((qx + qw <= ox) || (qx >= ox + obw));

  assign acc_o.x = axis_step(query_i.x, query_i.w, query_i.px, query_i.pw,
                             obst_i.x, obst_i.w, span_y, hold, v, mot_i.x, acc_i.x);
  assign acc_o.y = axis_step(query_i.y, query_i.h, query_i.py, query_i.ph,
                             obst_i.y, obst_i.h, span_x, hold, v, mot_i.y, acc_i.y);

endmodule

/* design/edge_resistance_geometry.sv */
// Edge resistance for a window that is being moved or resized. Software fills an obstacle
// table over the input stream (opcode 0 empties it, opcode 1 appends a rectangle, an append
// to a full table is dropped) and then sends queries (opcode 2) carrying the proposed and the
// previous geometry; each query returns one transfer with the adjusted geometry, saturated to
// the field ranges, and tuser set when resistance was enabled. Clear and append transfers give
// no result. A query is accepted, then each stored rectangle is read in turn from the single
// read port of the obstacle memory; the query then finishes and loads the output register.
// With resistance disabled a query goes from acceptance straight to the finish. The finish
// waits while a previous result is still held in the output register. The table needs no
// clearing pass after reset, since only entries below the fill count are ever read.
// Configuration writes are taken in any cycle, but should only be made while no query
// is in progress.
module edge_resistance_geometry import erg_pkg::*; #(
  parameter int unsigned MAX_OBSTACLES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: pos_x[15:0], pos_y[31:16], size_w[46:32], size_h[61:47],
  // rect_class[63:62], prev_x[79:64], prev_y[95:80], prev_w[110:96],
  // prev_h[125:111], zero padding[127:126].
  input  logic [127:0] s_axis_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: out_x[15:0], out_y[31:16], out_w[46:32], out_h[61:47],
  // zero padding[63:62].
  output logic [63:0]  m_axis_tdata,
  // tuser from bit 0: applied[0].
  output logic [0:0]   m_axis_tuser,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [9:0]   cfg_data_i
);

  localparam int unsigned AW    = MAX_OBSTACLES > 1 ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_OBSTACLES + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, idx_q;
  logic             rd_en, rd_vld_q;
  logic             load_out, s_fire;
  logic             enable_q, applied_q;
  resist_t          resist_q;
  query_t           query_q, query_in;
  motion_t          mot_q, mot_in;
  acc_t             acc_q, acc_next;
  obst_t            obst_in, obst_rd;
  logic [63:0]      rd_word;
  logic [1:0]       opcode;
  logic             tbl_we;

  logic               m_tvalid_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic [14:0]        out_w_q, out_h_q;
  logic               out_applied_q;

  // Unpack the input transfer.
  assign opcode           = s_axis_tuser;
  assign query_in.x       = s_axis_tdata[15:0];
  assign query_in.y       = s_axis_tdata[31:16];
  assign query_in.w       = s_axis_tdata[46:32];
  assign query_in.h       = s_axis_tdata[61:47];
  assign query_in.px      = s_axis_tdata[79:64];
  assign query_in.py      = s_axis_tdata[95:80];
  assign query_in.pw      = s_axis_tdata[110:96];
  assign query_in.ph      = s_axis_tdata[125:111];
  assign obst_in.x        = s_axis_tdata[15:0];
  assign obst_in.y        = s_axis_tdata[31:16];
  assign obst_in.w        = s_axis_tdata[46:32];
  assign obst_in.h        = s_axis_tdata[61:47];
  assign obst_in.kind     = s_axis_tdata[63:62];

  // Direction of motion and growth, worked out once when the query arrives.
  logic signed [16:0] dx, dy;
  logic signed [15:0] dw, dh;
  assign dx = 17'(query_in.x) - 17'(query_in.px);
  assign dy = 17'(query_in.y) - 17'(query_in.py);
  assign dw = $signed({1'b0, query_in.w}) - $signed({1'b0, query_in.pw});
  assign dh = $signed({1'b0, query_in.h}) - $signed({1'b0, query_in.ph});
  assign mot_in.x.pos_gt  = dx > 0;
  assign mot_in.x.pos_lt  = dx < 0;
  assign mot_in.x.size_gt = dw > 0;
  assign mot_in.x.size_ne = dw != 0;
  assign mot_in.y.pos_gt  = dy > 0;
  assign mot_in.y.pos_lt  = dy < 0;
  assign mot_in.y.size_gt = dh > 0;
  assign mot_in.y.size_ne = dh != 0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Appends go straight into the table at the fill count.
  assign tbl_we = s_fire && (opcode == OP_ADD) && (count_q < CNT_W'(MAX_OBSTACLES));

  erg_ram #(
    .WIDTH ($bits(obst_t)),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (obst_in),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_word)
  );

  assign obst_rd = rd_word;

  erg_eval u_eval (
    .query_i  (query_q),
    .mot_i    (mot_q),
    .obst_i   (obst_rd),
    .resist_i (resist_q),
    .acc_i    (acc_q),
    .acc_o    (acc_next)
  );

  // Sequencer: issue one table read a cycle while entries remain, then finish
  // once the output register is free.
  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (opcode == OP_QUERY)) begin
          state_d = enable_q ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      m_tvalid_q <= 1'b0;
      enable_q   <= 1'b1;
      resist_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (rd_en) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (s_fire) begin
        if (opcode == OP_CLEAR) begin
          count_q <= '0;
        end else if (tbl_we) begin
          count_q <= count_q + CNT_W'(1);
        end else if (opcode == OP_QUERY) begin
          idx_q <= '0;
        end
      end
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ENABLE: enable_q        <= cfg_data_i[0];
          CFG_SCREEN: resist_q.screen <= cfg_data_i;
          CFG_WINDOW: resist_q.window <= cfg_data_i;
          CFG_SHELF:  resist_q.shelf  <= cfg_data_i;
          default:    enable_q        <= enable_q;
        endcase
      end
    end
  end

  // Query payload and the running resistance, updated once per rectangle read.
  always_ff @(posedge clk_i) begin
    if (s_fire && (opcode == OP_QUERY)) begin
      query_q   <= query_in;
      mot_q     <= mot_in;
      applied_q <= enable_q;
      acc_q     <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_next;
    end
  end

  // Apply the resistance on moving axes and saturate to the field ranges.
  logic signed [16:0] sum_x, sum_y, sum_w, sum_h;
  logic signed [15:0] fin_x, fin_y;
  logic [14:0]        fin_w, fin_h;

  assign sum_x = 17'(query_q.x) + 17'(acc_q.x.r_pos);
  assign sum_y = 17'(query_q.y) + 17'(acc_q.y.r_pos);
  assign sum_w = $signed({2'b00, query_q.w}) + 17'(acc_q.x.r_size);
  assign sum_h = $signed({2'b00, query_q.h}) + 17'(acc_q.y.r_size);

  always_comb begin
    fin_x = query_q.x;
    fin_y = query_q.y;
    fin_w = query_q.w;
    fin_h = query_q.h;
    if (applied_q) begin
      if (mot_q.x.pos_gt || mot_q.x.pos_lt) begin
        if (sum_x > 17'sd32767)       fin_x = 16'sh7fff;
        else if (sum_x < -17'sd32768) fin_x = 16'sh8000;
        else                          fin_x = sum_x[15:0];
      end
      if (mot_q.y.pos_gt || mot_q.y.pos_lt) begin
        if (sum_y > 17'sd32767)       fin_y = 16'sh7fff;
        else if (sum_y < -17'sd32768) fin_y = 16'sh8000;
        else                          fin_y = sum_y[15:0];
      end
      if (mot_q.x.size_ne) begin
        if (sum_w < 0)                fin_w = '0;
        else if (sum_w > 17'sd32767)  fin_w = 15'h7fff;
        else                          fin_w = sum_w[14:0];
      end
      if (mot_q.y.size_ne) begin
        if (sum_h < 0)                fin_h = '0;
        else if (sum_h > 17'sd32767)  fin_h = 15'h7fff;
        else                          fin_h = sum_h[14:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q       <= fin_x;
      out_y_q       <= fin_y;
      out_w_q       <= fin_w;
      out_h_q       <= fin_h;
      out_applied_q <= applied_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {2'b00, out_h_q, out_w_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_applied_q;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_OBSTACLES))
    else $error("obstacle count beyond table depth");

  // Table data is only evaluated while a scan is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("table read returned outside a scan");

  // A result only appears from the finishing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the finishing step");

  // The scan index never runs past the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= count_q))
    else $error("scan index beyond fill count");
`endif

endmodule

/* verif/edge_resistance_geometry_checker.sv */
module edge_resistance_geometry_checker import erg_pkg::*; #(
  parameter int unsigned MAX_OBSTACLES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // tdata from bit 0: pos_x, pos_y, size_w, size_h, rect_class, prev_x, prev_y,
  // prev_w, prev_h, zero padding.
  input  logic [127:0] s_axis_tdata,
  // tuser from bit 0: opcode.
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: out_x, out_y, out_w, out_h, zero padding.
  input  logic [63:0]  m_axis_tdata,
  // tuser from bit 0: applied.
  input  logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [9:0]   cfg_data_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic               applied;
  } geom_t;

  // Shadow copy of the obstacle table and of the registers.
  longint      tab_x [MAX_OBSTACLES];
  longint      tab_y [MAX_OBSTACLES];
  longint      tab_w [MAX_OBSTACLES];
  longint      tab_h [MAX_OBSTACLES];
  logic [1:0]  tab_kind [MAX_OBSTACLES];
  int unsigned tab_n;

  logic        resist_on;
  logic [9:0]  screen_snap;
  logic [9:0]  window_snap;
  logic [9:0]  shelf_snap;

  geom_t       expected_geometry_q[$];
  int unsigned fails;

  // Two spans meet unless one lies wholly at or beyond the end of the other.
  function automatic bit spans_meet(longint a, longint a_len, longint b, longint b_len);
    return !((b + b_len <= a) || (b >= a + a_len));
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Resistance of one obstacle along one axis: a is the obstacle edge origin, p and s the
  // proposed position and size, pp and ps the previous ones.
  task automatic resist_axis(input longint a, input longint a_len, input longint p,
                             input longint s, input longint pp, input longint ps,
                             input longint dpos, input longint dsize, input bit hold,
                             input longint v, inout longint rpos, inout longint rsize);
    longint d;
    longint pd;
    if (dpos > 0) begin
      if (hold) begin
        d = p + s - (a + a_len);
        pd = pp + ps - (a + a_len);
        if (d > 0 && pd <= 0 && d <= v && -rpos < d) rpos = -d;
      end else begin
        d = a - (p + s);
        pd = a - (pp + ps);
        if (d < 0 && pd >= 0 && d >= -v && rpos > d) rpos = d;
      end
    end else if (dpos < 0) begin
      if (hold) begin
        d = a - p;
        pd = a - pp;
        if (d > 0 && pd <= 0 && d <= v && rpos < d) begin
          rpos = d;
          rsize = -d;
        end
      end else begin
        d = p - (a + a_len);
        pd = pp - (a + a_len);
        if (d < 0 && pd >= 0 && d >= -v && -rpos > d) begin
          rpos = -d;
          rsize = d;
        end
      end
    end
    // Growth with the position held moves only the far edge.
    if (dsize > 0 && dpos == 0) begin
      if (hold) begin
        d = p + s - (a + a_len);
        pd = pp + ps - (a + a_len);
        if (d > 0 && pd <= 0 && d <= v && -rsize < d) rsize = -d;
      end else begin
        d = a - (p + s);
        pd = a - (pp + ps);
        if (d < 0 && pd >= 0 && d >= -v && rsize > d) rsize = d;
      end
    end
  endtask

  task automatic resolve_geometry(input logic [127:0] d, output geom_t res);
    longint x, y, w, h, px, py, pw, ph;
    longint dx, dy, dw, dh;
    longint rsx, rsy, rsw, rsh;
    longint ox, oy, ow, oh, v;
    bit hold;
    logic [1:0] k;
    int unsigned i;
    x  = longint'($signed(d[15:0]));
    y  = longint'($signed(d[31:16]));
    w  = longint'(d[46:32]);
    h  = longint'(d[61:47]);
    px = longint'($signed(d[79:64]));
    py = longint'($signed(d[95:80]));
    pw = longint'(d[110:96]);
    ph = longint'(d[125:111]);
    ox = x;
    oy = y;
    ow = w;
    oh = h;
    res.applied = 1'b0;
    if (resist_on) begin
      res.applied = 1'b1;
      dx = x - px;
      dy = y - py;
      dw = w - pw;
      dh = h - ph;
      rsx = 0;
      rsy = 0;
      rsw = 0;
      rsh = 0;
      for (i = 0; i < tab_n; i++) begin
        k = tab_kind[i];
        hold = (k == KIND_SCREEN);
        v = (k == KIND_SCREEN) ? longint'(screen_snap) :
            ((k == KIND_WINDOW) ? longint'(window_snap) : longint'(shelf_snap));
        if (spans_meet(tab_y[i], tab_h[i], y, h))
          resist_axis(tab_x[i], tab_w[i], x, w, px, pw, dx, dw, hold, v, rsx, rsw);
        if (spans_meet(tab_x[i], tab_w[i], x, w))
          resist_axis(tab_y[i], tab_h[i], y, h, py, ph, dy, dh, hold, v, rsy, rsh);
      end
      if (dx != 0) ox = x + rsx;
      if (dy != 0) oy = y + rsy;
      if (dw != 0) ow = w + rsw;
      if (dh != 0) oh = h + rsh;
    end
    res.x = 16'(clamp_to(ox, -32768, 32767));
    res.y = 16'(clamp_to(oy, -32768, 32767));
    res.w = 15'(clamp_to(ow, 0, 32767));
    res.h = 15'(clamp_to(oh, 0, 32767));
  endtask

  function automatic int field_differs(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    geom_t want;
    geom_t got;
    if (!rst_ni) begin
      tab_n = 0;
      resist_on = 1'b1;
      screen_snap = '0;
      window_snap = '0;
      shelf_snap = '0;
      expected_geometry_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ENABLE: resist_on = cfg_data_i[0];
          CFG_SCREEN: screen_snap = cfg_data_i;
          CFG_WINDOW: window_snap = cfg_data_i;
          CFG_SHELF:  shelf_snap = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_CLEAR: tab_n = 0;
          OP_ADD: begin
            // A full table drops the append.
            if (tab_n < MAX_OBSTACLES) begin
              tab_x[tab_n] = longint'($signed(s_axis_tdata[15:0]));
              tab_y[tab_n] = longint'($signed(s_axis_tdata[31:16]));
              tab_w[tab_n] = longint'(s_axis_tdata[46:32]);
              tab_h[tab_n] = longint'(s_axis_tdata[61:47]);
              tab_kind[tab_n] = s_axis_tdata[63:62];
              tab_n++;
            end
          end
          OP_QUERY: begin
            resolve_geometry(s_axis_tdata, want);
            expected_geometry_q.push_back(want);
          end
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        got.w = m_axis_tdata[46:32];
        got.h = m_axis_tdata[61:47];
        got.applied = m_axis_tuser[0];
        if (expected_geometry_q.size() == 0) begin
          $error("result transfer with no query outstanding: x %0d y %0d w %0d h %0d",
                 $signed(got.x), $signed(got.y), got.w, got.h);
          fails++;
        end else begin
          want = expected_geometry_q.pop_front();
          fails += field_differs("out_x", longint'($signed(want.x)),
                                 longint'($signed(got.x)));
          fails += field_differs("out_y", longint'($signed(want.y)),
                                 longint'($signed(got.y)));
          fails += field_differs("out_w", longint'(want.w), longint'(got.w));
          fails += field_differs("out_h", longint'(want.h), longint'(got.h));
          fails += field_differs("applied", longint'(want.applied), longint'(got.applied));
        end
      end

      fail_count_o <= fails;
      pending_o <= expected_geometry_q.size();
    end
  end

endmodule

/* verif/edge_resistance_geometry_tb.sv */
// Stimulus and verdict for the edge resistance block. The checker beside the block watches
// every transfer, keeps its own obstacle table and predicts each query; this module only
// produces traffic, changes the registers between phases and reports the outcome.
module edge_resistance_geometry_tb;
  import erg_pkg::*;

  localparam int unsigned MAX_OBSTACLES = 64;
  // Generous bound: every item a full-table query behind the longest stalls on both sides,
  // taken several times over.
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0] KIND_SHELF = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         s_valid;
  logic         s_ready;
  logic [127:0] s_data;
  logic [1:0]   s_user;
  logic         m_valid;
  logic         m_ready;
  logic [63:0]  m_data;
  logic [0:0]   m_user;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [9:0]   cfg_data;

  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  cycle_count;

  // When set, neither side idles, so that stretches of back-to-back transfers occur.
  bit           calm;

  // A light copy of the rectangles sent, used only to aim queries at real edges.
  int           sh_x [MAX_OBSTACLES];
  int           sh_y [MAX_OBSTACLES];
  int           sh_w [MAX_OBSTACLES];
  int           sh_h [MAX_OBSTACLES];
  int unsigned  sh_n;

  edge_resistance_geometry #(
    .MAX_OBSTACLES(MAX_OBSTACLES)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  edge_resistance_geometry_checker #(
    .MAX_OBSTACLES(MAX_OBSTACLES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic int fit(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Motion step: none, a few pixels, tens of pixels, or up to 1100 pixels, past the largest snap distance.
  function automatic int rand_delta();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return int'($urandom_range(0, 12)) - 6;
      2:       return int'($urandom_range(0, 120)) - 60;
      default: return int'($urandom_range(0, 2200)) - 1100;
    endcase
  endfunction

  function automatic int rand_resist();
    case ($urandom_range(0, 4))
      0:       return 1023;
      1:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, 80);
    endcase
  endfunction

  function automatic logic [127:0] random_bits();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    v[127:126] = 2'b00;
    return v;
  endfunction

  // Packs one input item; every field is first saturated into its range.
  function automatic logic [127:0] pack_item(int x, int y, int w, int h, logic [1:0] cls,
                                             int px, int py, int pw, int ph);
    int fx, fy, fw, fh, fpx, fpy, fpw, fph;
    logic [127:0] v;
    fx  = fit(x, -32768, 32767);
    fy  = fit(y, -32768, 32767);
    fw  = fit(w, 0, 32767);
    fh  = fit(h, 0, 32767);
    fpx = fit(px, -32768, 32767);
    fpy = fit(py, -32768, 32767);
    fpw = fit(pw, 0, 32767);
    fph = fit(ph, 0, 32767);
    v = '0;
    v[15:0]    = fx[15:0];
    v[31:16]   = fy[15:0];
    v[46:32]   = fw[14:0];
    v[61:47]   = fh[14:0];
    v[63:62]   = cls;
    v[79:64]   = fpx[15:0];
    v[95:80]   = fpy[15:0];
    v[110:96]  = fpw[14:0];
    v[125:111] = fph[14:0];
    return v;
  endfunction

  // One input transfer. Valid stays high on return, so that a following item may go out
  // in the very next cycle; a gap, if one is drawn, is opened at the next falling edge.
  task automatic send_item(input logic [1:0] op, input logic [127:0] data);
    int unsigned gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid = 1'b1;
    s_user = op;
    s_data = data;
    do @(posedge clk); while (!s_ready);
    if (op == OP_CLEAR) sh_n = 0;
    if (op == OP_ADD && sh_n < MAX_OBSTACLES) begin
      sh_x[sh_n] = int'($signed(data[15:0]));
      sh_y[sh_n] = int'($signed(data[31:16]));
      sh_w[sh_n] = int'(data[46:32]);
      sh_h[sh_n] = int'(data[61:47]);
      sh_n++;
    end
  endtask

  // Drops valid, waits for every outstanding result, then allows the block a full query's
  // worth of cycles, since clear and append transfers never answer.
  task automatic settle();
    @(negedge clk);
    s_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAX_OBSTACLES + 8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value[9:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_random_obstacle();
    int x, y, w, h;
    logic [1:0] cls;
    cls = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      // Anywhere in the coordinate space, at any size.
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      w = $urandom_range(0, 32767);
      h = $urandom_range(0, 32767);
    end else begin
      x = int'($urandom_range(0, 3000)) - 1500;
      y = int'($urandom_range(0, 3000)) - 1500;
      w = (cls == KIND_SCREEN) ? $urandom_range(200, 3000) : $urandom_range(0, 800);
      h = (cls == KIND_SCREEN) ? $urandom_range(200, 3000) : $urandom_range(0, 800);
      if ($urandom_range(0, 19) == 0) w = 0;
    end
    send_item(OP_ADD, pack_item(x, y, w, h, cls,
                                int'($urandom_range(0, 65535)) - 32768,
                                int'($urandom_range(0, 65535)) - 32768,
                                $urandom_range(0, 32767), $urandom_range(0, 32767)));
  endtask

  // Result side: ready drops for random stretches.
  initial begin : result_sink
    int unsigned stall_left;
    m_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        m_ready = 1'b1;
        stall_left = pick_gap();
      end else begin
        m_ready = 1'b0;
        stall_left--;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("edge_resistance_geometry test failed");
    $finish;
  end

  initial begin : stimulus
    int phase, k, n_obst, n_items;
    int unsigned r, o;
    int ax, ay, aw, ah, px, py, pw, ph, x, y, w, h, e_pos;
    bit on_y;
    logic [1:0] op;
    logic en;

    rst_n = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = OP_CLEAR;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    calm = 1'b0;
    sh_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A query against the empty table, at the field extremes, under the
    // reset settings: the proposal must come back untouched with resistance applied.
    send_item(OP_QUERY, pack_item(-32768, 32767, 32767, 0, KIND_SCREEN,
                                  32767, -32768, 0, 32767));
    settle();
    cfg_write(CFG_SCREEN, 40);
    cfg_write(CFG_WINDOW, 30);
    cfg_write(CFG_SHELF, 25);

    // A screen, a window in it, a shelf along its foot, an obstacle of the fourth class
    // (which must act as a shelf) and one of zero size.
    send_item(OP_ADD, pack_item(0, 0, 1920, 1080, KIND_SCREEN, 0, 0, 0, 0));
    send_item(OP_ADD, pack_item(500, 200, 300, 300, KIND_WINDOW, 0, 0, 0, 0));
    send_item(OP_ADD, pack_item(0, 1050, 1920, 30, KIND_SHELF, 0, 0, 0, 0));
    send_item(OP_ADD, pack_item(1000, 600, 50, 50, KIND_SPARE, 0, 0, 0, 0));
    send_item(OP_ADD, pack_item(100, 100, 0, 0, KIND_WINDOW, 0, 0, 0, 0));
    // Leaving the screen to the right, to the left and over the top.
    send_item(OP_QUERY, pack_item(1630, 100, 300, 200, KIND_SCREEN, 1600, 100, 300, 200));
    send_item(OP_QUERY, pack_item(-20, 100, 200, 200, KIND_SCREEN, 5, 100, 200, 200));
    send_item(OP_QUERY, pack_item(300, -15, 100, 100, KIND_SCREEN, 300, 10, 100, 100));
    // Entering the window from the left and from the right.
    send_item(OP_QUERY, pack_item(220, 250, 300, 100, KIND_SCREEN, 150, 250, 300, 100));
    send_item(OP_QUERY, pack_item(790, 300, 100, 100, KIND_SCREEN, 810, 300, 100, 100));
    // Widening into the window with the left edge held.
    send_item(OP_QUERY, pack_item(150, 250, 370, 100, KIND_SCREEN, 150, 250, 300, 100));
    // Dropping onto the shelf; growing in height past the screen foot.
    send_item(OP_QUERY, pack_item(100, 820, 200, 240, KIND_SCREEN, 100, 800, 200, 240));
    send_item(OP_QUERY, pack_item(700, 900, 100, 190, KIND_SCREEN, 700, 900, 100, 140));
    // Entering the fourth-class obstacle from above.
    send_item(OP_QUERY, pack_item(1000, 520, 50, 90, KIND_SCREEN, 1000, 500, 50, 90));
    // Sweeping across the zero-size rectangle.
    send_item(OP_QUERY, pack_item(105, 90, 10, 20, KIND_SCREEN, 80, 90, 10, 20));
    // No motion at all.
    send_item(OP_QUERY, pack_item(400, 400, 50, 50, KIND_SCREEN, 400, 400, 50, 50));
    // Held at the left screen edge while shrinking, so the width saturates at zero.
    send_item(OP_QUERY, pack_item(-35, 300, 10, 50, KIND_SCREEN, 0, 300, 20, 50));
    // The unused opcode is ignored.
    send_item(OP_SPARE, random_bits());
    // Clearing leaves nothing to resist against.
    send_item(OP_CLEAR, random_bits());
    send_item(OP_QUERY, pack_item(-50, 40, 300, 200, KIND_SCREEN, 10, 70, 250, 260));
    // A rectangle at the corner extremes, then disabled resistance.
    send_item(OP_ADD, pack_item(32767, -32768, 32767, 32767, KIND_WINDOW, 0, 0, 0, 0));
    send_item(OP_QUERY, pack_item(32767, -32768, 32767, 32767, KIND_SCREEN,
                                  32700, -32700, 32000, 32000));
    settle();
    cfg_write(CFG_ENABLE, 0);
    send_item(OP_QUERY, pack_item(1630, 100, 300, 200, KIND_SCREEN, 1600, 100, 300, 200));

    // Random part, in phases with their own settings. Most traffic is a small table and
    // queries whose previous geometry sits on or near an obstacle edge.
    for (phase = 0; phase < 10; phase++) begin
      settle();
      calm = (phase % 4 == 3);
      case (phase)
        0: begin
          cfg_write(CFG_ENABLE, 1);
          cfg_write(CFG_SCREEN, 1023);
          cfg_write(CFG_WINDOW, 1023);
          cfg_write(CFG_SHELF, 1023);
        end
        1: begin
          cfg_write(CFG_SCREEN, 0);
          cfg_write(CFG_WINDOW, 0);
          cfg_write(CFG_SHELF, 0);
        end
        default: begin
          en = (phase != 2);
          cfg_write(CFG_ENABLE, int'(en));
          cfg_write(CFG_SCREEN, rand_resist());
          cfg_write(CFG_WINDOW, rand_resist());
          cfg_write(CFG_SHELF, rand_resist());
        end
      endcase

      send_item(OP_CLEAR, random_bits());
      // One phase overfills the table, so that appends to a full table are dropped.
      n_obst = (phase == 5) ? MAX_OBSTACLES + 6 : $urandom_range(1, 12);
      n_items = (phase == 5) ? 25 : 60;
      for (k = 0; k < n_obst; k++) add_random_obstacle();

      for (k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80 && sh_n != 0) begin
          o = $urandom_range(0, sh_n - 1);
          ax = sh_x[o];
          ay = sh_y[o];
          aw = sh_w[o];
          ah = sh_h[o];
          pw = $urandom_range(1, 400);
          ph = $urandom_range(1, 400);
          on_y = 1'($urandom_range(0, 1));
          // Put one edge of the previous geometry a few pixels from an obstacle edge on
          // the chosen axis, with the other axis overlapping the obstacle.
          if (!on_y) begin
            e_pos = $urandom_range(0, 1) ? ax : ax + aw;
            px = ($urandom_range(0, 1) ? e_pos - pw : e_pos) + int'($urandom_range(0, 16)) - 8;
            py = ay + int'($urandom_range(0, ah)) - int'($urandom_range(0, ph));
            x = px + rand_delta();
            y = py + (($urandom_range(0, 9) < 6) ? 0 : rand_delta());
          end else begin
            e_pos = $urandom_range(0, 1) ? ay : ay + ah;
            py = ($urandom_range(0, 1) ? e_pos - ph : e_pos) + int'($urandom_range(0, 16)) - 8;
            px = ax + int'($urandom_range(0, aw)) - int'($urandom_range(0, pw));
            y = py + rand_delta();
            x = px + (($urandom_range(0, 9) < 6) ? 0 : rand_delta());
          end
          w = pw + ($urandom_range(0, 1) ? 0 : rand_delta());
          h = ph + ($urandom_range(0, 1) ? 0 : rand_delta());
          send_item(OP_QUERY, pack_item(x, y, w, h, 2'($urandom_range(0, 3)), px, py, pw, ph));
        end else if (r < 90) begin
          // Noise: raw bits under any opcode.
          case ($urandom_range(0, 9))
            0:       op = OP_CLEAR;
            1, 2:    op = OP_ADD;
            3:       op = OP_SPARE;
            default: op = OP_QUERY;
          endcase
          send_item(op, random_bits());
        end else if (r < 97 || sh_n == 0) begin
          add_random_obstacle();
        end else begin
          send_item(OP_SPARE, random_bits());
        end
      end
    end

    settle();
    if (fail_count == 0) $display("edge_resistance_geometry test passed");
    else $display("edge_resistance_geometry test failed");
    $finish;
  end

endmodule

/* edge_resistance_geometry.f */
design/erg_pkg.sv
design/erg_ram.sv
design/erg_eval.sv
design/edge_resistance_geometry.sv
verif/edge_resistance_geometry_checker.sv
verif/edge_resistance_geometry_tb.sv
